FILE: hw/rtl/rmc_pkg.sv
// rmc_pkg: shared constants, codes and the neighbour check of the maze carver
// no dependencies; used by rmc_mod_unit, random_maze_carver and rmc_checker
package rmc_pkg;

  localparam int MaxSide = 32;
  localparam int SideW   = 5;
  localparam int CellW   = 10;
  localparam int Cells   = MaxSide * MaxSide;
  localparam int CntW    = 11;
  localparam int CfgW    = 6;
  localparam int CfgIdxW = 2;
  localparam int DrawW   = 16;

  localparam logic [1:0] WAY_EAST  = 2'd0;
  localparam logic [1:0] WAY_WEST  = 2'd1;
  localparam logic [1:0] WAY_SOUTH = 2'd2;
  localparam logic [1:0] WAY_NORTH = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_GRID_COLS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GRID_ROWS = 2'd1;

  // rows are visited masks with out-of-grid bits already set
  function automatic logic cell_open(logic [MaxSide-1:0] up, logic [MaxSide-1:0] mid,
                                     logic [MaxSide-1:0] dn, logic [SideW-1:0] b,
                                     logic [CfgW-1:0] cols);
    logic e;
    logic w;
    e = (({1'b0, b} + 6'd1) < cols) && !mid[b + 5'd1];
    w = (b != '0) && !mid[b - 5'd1];
    return e || w || !dn[b] || !up[b];
  endfunction

endpackage

FILE: hw/rtl/rmc_mod_unit.sv
// rmc_mod_unit: iterative restoring remainder, one quotient bit per cycle
// depends on rmc_pkg
module rmc_mod_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rmc_pkg::DrawW-1:0] num_i,
  input  logic [rmc_pkg::CntW-1:0]  den_i,
  output logic                     done_o,
  output logic [rmc_pkg::CntW-1:0]  rem_o
);

  logic [rmc_pkg::DrawW-1:0] num_q, num_d;
  logic [rmc_pkg::CntW-1:0]  den_q, den_d;
  logic [rmc_pkg::CntW:0]    rem_q, rem_d;
  logic [4:0]                cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;

  always_comb begin
    logic [rmc_pkg::CntW:0] t;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    t      = {rem_q[rmc_pkg::CntW-1:0], num_q[rmc_pkg::DrawW-1]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = 5'(rmc_pkg::DrawW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = (t >= {1'b0, den_q}) ? t - {1'b0, den_q} : t;
      num_d = {num_q[rmc_pkg::DrawW-2:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[rmc_pkg::CntW-1:0];

endmodule

FILE: hw/rtl/random_maze_carver.sv
// random_maze_carver: randomized frontier maze generator, top level
// depends on rmc_pkg and rmc_mod_unit
//
// usage: the input channel (in_valid_i / in_stall_o) takes one command item;
// cmd 0 starts a new maze at (start_row, start_col), cmd 1 carves at most one passage.
// every item that no config write cuts off gives exactly one result item
// on the output channel (out_valid_o / out_stall_i). the config channel
// (cfg_valid_i / cfg_ready_o) sets grid_cols (index 0) and grid_rows
// (index 1); a write wipes the maze. one item at a time: in_stall_o is high
// from acceptance until the result is loaded into the output register, which
// can hold one result while the next item is already being worked on.
// a start runs the clear of all 32 rows of the visited map, one row per cycle.
// a carve: the remainder unit picks the frontier entry, two five-row window
// reads of the visited map check neighbours, and the frontier list is
// compacted through its read and write ports, one entry per cycle.
// reset: config back to 16x16, counts cleared, a clear of all 32 rows of the
// visited map runs before the first item is taken. a stalled receiver holds
// the result; the block finishes the next item and then waits.
module random_maze_carver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [4:0]                  start_row_i,
  input  logic [4:0]                  start_col_i,
  input  logic [15:0]                 pick_draw_i,
  input  logic [1:0]                  way_draw_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [4:0]                  from_row_o,
  output logic [4:0]                  from_col_o,
  output logic [4:0]                  to_row_o,
  output logic [4:0]                  to_col_o,
  output logic [1:0]                  way_o,
  output logic                        carved_o,
  output logic                        done_res_o,
  output logic [10:0]                 frontier_left_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rmc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rmc_pkg::CfgW-1:0]    cfg_data_i
);

  localparam int MS = rmc_pkg::MaxSide;
  localparam int SW = rmc_pkg::SideW;
  localparam int CW = rmc_pkg::CellW;
  localparam int NW = rmc_pkg::CntW;

  localparam logic [rmc_pkg::CfgIdxW-1:0] REG_GRID_COLS_L = rmc_pkg::REG_GRID_COLS;
  localparam logic [rmc_pkg::CfgIdxW-1:0] REG_GRID_ROWS_L = rmc_pkg::REG_GRID_ROWS;
  localparam logic [1:0] WAY_EAST  = rmc_pkg::WAY_EAST;
  localparam logic [1:0] WAY_WEST  = rmc_pkg::WAY_WEST;
  localparam logic [1:0] WAY_SOUTH = rmc_pkg::WAY_SOUTH;
  localparam logic [1:0] WAY_NORTH = rmc_pkg::WAY_NORTH;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_DIV, S_PICK, S_PICKW, S_WIN, S_WINW,
    S_CHOOSE, S_EVAL, S_COMPACT, S_APPEND, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic [rmc_pkg::CfgW-1:0] cols_q, cols_d, rows_q, rows_d;
  logic [SW-1:0] clr_q, clr_d;
  logic          start_pend_q, start_pend_d;
  logic [SW-1:0] sr_q, sr_d, sc_q, sc_d;
  logic [1:0]    wayd_q, wayd_d;
  logic [NW-1:0] fcnt_q, fcnt_d, vcnt_q, vcnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [SW-1:0] r_q, r_d, c_q, c_d, tr_q, tr_d, tc_q, tc_d, center_q, center_d;
  logic [1:0]    way_q, way_d;
  logic          carved_q, carved_d;
  logic [2:0]    k_q, k_d;
  logic          pass2_q, pass2_d, rowok_q, rowok_d;
  logic [MS-1:0] win_q [5];
  logic [MS-1:0] win_d [5];
  logic [NW-1:0] rdi_q, rdi_d, w_q, w_d;
  logic          pv_q, pv_d, alive_q, alive_d;
  logic [3:0]    dead_q, dead_d;
  logic [CW-1:0] dcel_q [4];
  logic [CW-1:0] dcel_d [4];

  logic          out_valid_q, out_valid_d;
  logic [SW-1:0] ofr_q, ofr_d, ofc_q, ofc_d, otr_q, otr_d, otc_q, otc_d;
  logic [1:0]    oway_q, oway_d;
  logic          ocarved_q, ocarved_d, odone_q, odone_d;
  logic [NW-1:0] oleft_q, oleft_d;

  // memories
  logic [MS-1:0] vis_mem [MS];
  logic [MS-1:0] vis_rd_q, vis_wd;
  logic [SW-1:0] vis_ra, vis_wa;
  logic          vis_re, vis_we;
  logic [CW-1:0] fr_mem [rmc_pkg::Cells];
  logic [CW-1:0] fr_rd_q, fr_wd, fr_ra, fr_wa;
  logic          fr_re, fr_we;

  logic          div_start, div_done;
  logic [NW-1:0] div_rem;

  logic [rmc_pkg::CfgW-1:0] rows_e, cols_e;
  logic [NW-1:0]            area;
  logic [MS-1:0]            colmask;

  assign rows_e = (rows_q < 6'd2) ? 6'd2 : (rows_q > 6'(MS)) ? 6'(MS) : rows_q;
  assign cols_e = (cols_q < 6'd2) ? 6'd2 : (cols_q > 6'(MS)) ? 6'(MS) : cols_q;
  assign area   = {5'b0, rows_e} * {5'b0, cols_e};

  always_comb begin
    for (int j = 0; j < MS; j++) begin
      colmask[j] = (6'(j) >= cols_e);
    end
  end

  // the draw is taken straight from the port on the accepting edge
  rmc_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (pick_draw_i),
    .den_i  (fcnt_q),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  always_comb begin
    logic [6:0]    rowv;
    logic [3:0]    ok;
    logic          found;
    logic [1:0]    d;
    logic [1:0]    dsel;
    logic [CW-1:0] e;
    logic          drop;
    state_d      = state_q;
    cols_d       = cols_q;
    rows_d       = rows_q;
    clr_d        = clr_q;
    start_pend_d = start_pend_q;
    sr_d         = sr_q;
    sc_d         = sc_q;
    wayd_d       = wayd_q;
    fcnt_d       = fcnt_q;
    vcnt_d       = vcnt_q;
    idx_d        = idx_q;
    r_d          = r_q;
    c_d          = c_q;
    tr_d         = tr_q;
    tc_d         = tc_q;
    center_d     = center_q;
    way_d        = way_q;
    carved_d     = carved_q;
    k_d          = k_q;
    pass2_d      = pass2_q;
    rowok_d      = rowok_q;
    win_d        = win_q;
    rdi_d        = rdi_q;
    w_d          = w_q;
    pv_d         = 1'b0;
    alive_d      = alive_q;
    dead_d       = dead_q;
    dcel_d       = dcel_q;
    out_valid_d  = out_valid_q;
    ofr_d        = ofr_q;
    ofc_d        = ofc_q;
    otr_d        = otr_q;
    otc_d        = otc_q;
    oway_d       = oway_q;
    ocarved_d    = ocarved_q;
    odone_d      = odone_q;
    oleft_d      = oleft_q;
    vis_re       = 1'b0;
    vis_ra       = '0;
    vis_we       = 1'b0;
    vis_wa       = '0;
    vis_wd       = '0;
    fr_re        = 1'b0;
    fr_ra        = '0;
    fr_we        = 1'b0;
    fr_wa        = '0;
    fr_wd        = '0;
    div_start    = 1'b0;
    rowv         = {2'b0, center_q} + {4'b0, k_q};
    ok           = '0;
    found        = 1'b0;
    d            = '0;
    dsel         = '0;
    e            = fr_rd_q;
    drop         = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        vis_we = 1'b1;
        vis_wa = clr_q;
        clr_d  = clr_q + 5'd1;
        if (clr_q == 5'(MS - 1)) begin
          state_d = start_pend_q ? S_START : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          wayd_d   = way_draw_i;
          carved_d = 1'b0;
          if (!cmd_i) begin
            sr_d = ({1'b0, start_row_i} >= rows_e) ? SW'(rows_e - 6'd1) : start_row_i;
            sc_d = ({1'b0, start_col_i} >= cols_e) ? SW'(cols_e - 6'd1) : start_col_i;
            start_pend_d = 1'b1;
            clr_d        = '0;
            state_d      = S_CLEAR;
          end else if (fcnt_q == '0) begin
            state_d = S_OUT;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_START: begin
        vis_we       = 1'b1;
        vis_wa       = sr_q;
        vis_wd       = MS'(1) << sc_q;
        fr_we        = 1'b1;
        fr_wa        = '0;
        fr_wd        = {sr_q, sc_q};
        fcnt_d       = NW'(1);
        vcnt_d       = NW'(1);
        start_pend_d = 1'b0;
        state_d      = S_OUT;
      end
      S_DIV: begin
        if (div_done) begin
          idx_d   = div_rem[CW-1:0];
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        fr_re   = 1'b1;
        fr_ra   = idx_q;
        state_d = S_PICKW;
      end
      S_PICKW: begin
        r_d      = fr_rd_q[CW-1:SW];
        c_d      = fr_rd_q[SW-1:0];
        center_d = fr_rd_q[CW-1:SW];
        k_d      = '0;
        pass2_d  = 1'b0;
        state_d  = S_WIN;
      end
      S_WIN: begin
        vis_re  = 1'b1;
        vis_ra  = SW'(rowv - 7'd2);
        rowok_d = (rowv >= 7'd2) && ((rowv - 7'd2) < {1'b0, rows_e});
        state_d = S_WINW;
      end
      S_WINW: begin
        // rows outside the grid look fully visited
        win_d[k_q] = rowok_q ? (vis_rd_q | colmask) : '1;
        k_d        = k_q + 3'd1;
        if (k_q == 3'd4) begin
          state_d = pass2_q ? S_EVAL : S_CHOOSE;
        end else begin
          state_d = S_WIN;
        end
      end
      S_CHOOSE: begin
        ok[WAY_EAST]  = (({1'b0, c_q} + 6'd1) < cols_e) && !win_q[2][c_q + 5'd1];
        ok[WAY_WEST]  = (c_q != '0) && !win_q[2][c_q - 5'd1];
        ok[WAY_SOUTH] = !win_q[3][c_q];
        ok[WAY_NORTH] = !win_q[1][c_q];
        // rotating search from the drawn direction
        for (int k = 0; k < 4; k++) begin
          d = wayd_q + 2'(k);
          if (!found && ok[d]) begin
            found = 1'b1;
            dsel  = d;
          end
        end
        if (found) begin
          carved_d = 1'b1;
          way_d    = dsel;
          tr_d     = r_q;
          tc_d     = c_q;
          vis_wd   = win_q[2];
          case (dsel)
            WAY_EAST:  tc_d = c_q + 5'd1;
            WAY_WEST:  tc_d = c_q - 5'd1;
            WAY_SOUTH: begin
              tr_d   = r_q + 5'd1;
              vis_wd = win_q[3];
            end
            default: begin
              tr_d   = r_q - 5'd1;
              vis_wd = win_q[1];
            end
          endcase
          vis_we   = 1'b1;
          vis_wa   = tr_d;
          vis_wd   = vis_wd | (MS'(1) << tc_d);
          vcnt_d   = vcnt_q + NW'(1);
          center_d = tr_d;
          k_d      = '0;
          pass2_d  = 1'b1;
          state_d  = S_WIN;
        end else begin
          state_d = S_OUT;
        end
      end
      S_EVAL: begin
        alive_d   = rmc_pkg::cell_open(win_q[1], win_q[2], win_q[3], tc_q, cols_e);
        dead_d[0] = (({1'b0, tc_q} + 6'd1) < cols_e) && win_q[2][tc_q + 5'd1] &&
                    !rmc_pkg::cell_open(win_q[1], win_q[2], win_q[3], tc_q + 5'd1, cols_e);
        dcel_d[0] = {tr_q, tc_q + 5'd1};
        dead_d[1] = (tc_q != '0) && win_q[2][tc_q - 5'd1] &&
                    !rmc_pkg::cell_open(win_q[1], win_q[2], win_q[3], tc_q - 5'd1, cols_e);
        dcel_d[1] = {tr_q, tc_q - 5'd1};
        dead_d[2] = (({1'b0, tr_q} + 6'd1) < rows_e) && win_q[3][tc_q] &&
                    !rmc_pkg::cell_open(win_q[2], win_q[3], win_q[4], tc_q, cols_e);
        dcel_d[2] = {tr_q + 5'd1, tc_q};
        dead_d[3] = (tr_q != '0) && win_q[1][tc_q] &&
                    !rmc_pkg::cell_open(win_q[0], win_q[1], win_q[2], tc_q, cols_e);
        dcel_d[3] = {tr_q - 5'd1, tc_q};
        rdi_d     = '0;
        w_d       = '0;
        state_d   = S_COMPACT;
      end
      S_COMPACT: begin
        // only neighbours of the new cell can have lost their last open side
        if (rdi_q < fcnt_q) begin
          fr_re = 1'b1;
          fr_ra = rdi_q[CW-1:0];
          rdi_d = rdi_q + NW'(1);
          pv_d  = 1'b1;
        end
        if (pv_q) begin
          for (int j = 0; j < 4; j++) begin
            if (dead_q[j] && (dcel_q[j] == e)) begin
              drop = 1'b1;
            end
          end
          if (!drop) begin
            fr_we = 1'b1;
            fr_wa = w_q[CW-1:0];
            fr_wd = e;
            w_d   = w_q + NW'(1);
          end
        end
        if (!fr_re && !pv_q) begin
          state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        fcnt_d = w_q;
        if (alive_q && (w_q < NW'(rmc_pkg::Cells))) begin
          fr_we  = 1'b1;
          fr_wa  = w_q[CW-1:0];
          fr_wd  = {tr_q, tc_q};
          fcnt_d = w_q + NW'(1);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          ofr_d       = carved_q ? r_q : '0;
          ofc_d       = carved_q ? c_q : '0;
          otr_d       = carved_q ? tr_q : '0;
          otc_d       = carved_q ? tc_q : '0;
          oway_d      = carved_q ? way_q : WAY_EAST;
          ocarved_d   = carved_q;
          odone_d     = (vcnt_q == area);
          oleft_d     = fcnt_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_valid_i && ((cfg_index_i == REG_GRID_COLS_L) || (cfg_index_i == REG_GRID_ROWS_L))) begin
      if (cfg_index_i == REG_GRID_COLS_L) begin
        cols_d = cfg_data_i;
      end else begin
        rows_d = cfg_data_i;
      end
      fcnt_d       = '0;
      vcnt_d       = '0;
      clr_d        = '0;
      start_pend_d = 1'b0;
      state_d      = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cols_q       <= 6'd16;
      rows_q       <= 6'd16;
      clr_q        <= '0;
      start_pend_q <= 1'b0;
      fcnt_q       <= '0;
      vcnt_q       <= '0;
      k_q          <= '0;
      pass2_q      <= 1'b0;
      rdi_q        <= '0;
      w_q          <= '0;
      pv_q         <= 1'b0;
      carved_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cols_q       <= cols_d;
      rows_q       <= rows_d;
      clr_q        <= clr_d;
      start_pend_q <= start_pend_d;
      fcnt_q       <= fcnt_d;
      vcnt_q       <= vcnt_d;
      k_q          <= k_d;
      pass2_q      <= pass2_d;
      rdi_q        <= rdi_d;
      w_q          <= w_d;
      pv_q         <= pv_d;
      carved_q     <= carved_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q      <= sr_d;
    sc_q      <= sc_d;
    wayd_q    <= wayd_d;
    idx_q     <= idx_d;
    r_q       <= r_d;
    c_q       <= c_d;
    tr_q      <= tr_d;
    tc_q      <= tc_d;
    center_q  <= center_d;
    way_q     <= way_d;
    rowok_q   <= rowok_d;
    win_q     <= win_d;
    alive_q   <= alive_d;
    dead_q    <= dead_d;
    dcel_q    <= dcel_d;
    ofr_q     <= ofr_d;
    ofc_q     <= ofc_d;
    otr_q     <= otr_d;
    otc_q     <= otc_d;
    oway_q    <= oway_d;
    ocarved_q <= ocarved_d;
    odone_q   <= odone_d;
    oleft_q   <= oleft_d;
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    if (vis_re) begin
      vis_rd_q <= vis_mem[vis_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      fr_mem[fr_wa] <= fr_wd;
    end
    if (fr_re) begin
      fr_rd_q <= fr_mem[fr_ra];
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign from_row_o      = ofr_q;
  assign from_col_o      = ofc_q;
  assign to_row_o        = otr_q;
  assign to_col_o        = otc_q;
  assign way_o           = oway_q;
  assign carved_o        = ocarved_q;
  assign done_res_o      = odone_q;
  assign frontier_left_o = oleft_q;

endmodule

FILE: hw/rtl/rmc_checker.sv
// rmc_checker: port-level checks of the maze carver, bound to the top level
// depends on rmc_pkg and the ports of random_maze_carver
module rmc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        cmd_i,
  input logic [4:0]                  start_row_i,
  input logic [4:0]                  start_col_i,
  input logic [15:0]                 pick_draw_i,
  input logic [1:0]                  way_draw_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [4:0]                  from_row_o,
  input logic [4:0]                  from_col_o,
  input logic [4:0]                  to_row_o,
  input logic [4:0]                  to_col_o,
  input logic [1:0]                  way_o,
  input logic                        carved_o,
  input logic                        done_res_o,
  input logic [10:0]                 frontier_left_o,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [rmc_pkg::CfgIdxW-1:0] cfg_index_i,
  input logic [rmc_pkg::CfgW-1:0]    cfg_data_i
);

  // a held result stays valid with to_row_o and to_col_o unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(to_row_o) && $stable(to_col_o))
    else $error("result changed while stalled");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken while busy");

  // a carved passage joins two adjacent cells
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && carved_o |->
      ((from_row_o == to_row_o) &&
       ((to_col_o == from_col_o + 5'd1) || (from_col_o == to_col_o + 5'd1))) ||
      ((from_col_o == to_col_o) &&
       ((to_row_o == from_row_o + 5'd1) || (from_row_o == to_row_o + 5'd1))))
    else $error("carve not between neighbours");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !carved_o |-> (from_row_o == '0) && (to_col_o == '0) && (way_o == '0))
    else $error("idle result not zeroed");

  // a finished maze has no frontier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> (frontier_left_o == '0))
    else $error("frontier left after completion");

endmodule

bind random_maze_carver rmc_checker u_rmc_checker (.*);
